[sv/tcad_pkg.sv]
// ============================================================================
// tcad_pkg: shared types and constants for the touch channel averager
// Field widths, op codes, register map and the mask bit mapping.
// ============================================================================
package tcad_pkg;

    localparam int COUNT_W   = 14;   // raw and smoothed count
    localparam int CH_W      = 3;    // channel field
    localparam int SENS_W    = 16;   // sensitivity register
    localparam int ACC_W     = 24;   // baseline accumulator
    localparam int THR_W     = 17;   // touch threshold
    localparam int MASK_W    = 5;    // touch mask
    localparam int SWEEP_W   = 10;   // calibration sweep counter

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_RESTART = 1'b1
    } op_t;

    localparam logic [PADDR_W-1:0] ADDR_SENSITIVITY = 3'd0;

    // Channels 0 and 1 swap places in the mask.
    function automatic logic [CH_W-1:0] mask_bit_of(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] b;
        case (ch)
            3'd0:    b = 3'd1;
            3'd1:    b = 3'd0;
            default: b = ch;
        endcase
        return b;
    endfunction

endpackage

[sv/tcad_ring_mem.sv]
// ============================================================================
// tcad_ring_mem: sample ring storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module tcad_ring_mem #(
    parameter int DEPTH  = 40,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 14
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/touch_channel_averager_detector.sv]
// ============================================================================
// touch_channel_averager_detector: moving average and touch threshold
// Per-channel ring averaging, baseline calibration and touch mask update.
// ============================================================================
// Usage:
//   s_ channel: one transaction per item. s_tuser is the op (sample or
//   restart calibration), s_tdata carries channel and raw count.
//   m_ channel: exactly one result transaction per input transaction, in
//   order. m_tdata carries smoothed, touched and touch mask, m_tuser the
//   calibrating flag.
//   APB port: one register, sensitivity, at address 0. Write it only while
//   the block is idle.
// Throughput: one item per cycle, except while stalled or during the
//   threshold load pass. An input transaction passes, in order, through the
//   ring RAM read, sum update, divide-by-depth multiply and accumulate/compare
//   into the output register that drives m_tvalid. When the final
//   calibration sweep completes, a threshold load pass walks the channels
//   through the shared reciprocal multiplier; s_tready is low while it runs.
// Reset: all state clears, calibration starts over, sensitivity is zero.
//   Ring RAM contents are not cleared; a per-channel wrap flag makes
//   unwritten entries read as zero, so there is no clearing pass.
// Stall: when m_tready is low with a result held, the whole pipeline holds
//   and s_tready drops in the same cycle; no result is dropped.
// ============================================================================
module touch_channel_averager_detector #(
    parameter int AVG_DEPTH    = 8,
    parameter int NUM_CHANNELS = 5,
    parameter int CAL_SWEEPS   = 1000
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcad_pkg::S_TDATA_W-1:0]    s_tdata,  // [2:0] channel, [16:3] raw_count
    input  logic                              s_tuser,  // [0] op
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tcad_pkg::M_TDATA_W-1:0]    m_tdata,  // [13:0] smoothed, [14] touched,
                                                        // [19:15] touch_mask
    output logic                              m_tuser,  // [0] calibrating
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcad_pkg::PADDR_W-1:0]      paddr,
    input  logic [tcad_pkg::PDATA_W-1:0]      pwdata,
    output logic [tcad_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int COUNT_W  = tcad_pkg::COUNT_W;
    localparam int CH_W     = tcad_pkg::CH_W;
    localparam int ACC_W    = tcad_pkg::ACC_W;
    localparam int THR_W    = tcad_pkg::THR_W;
    localparam int MASK_W   = tcad_pkg::MASK_W;
    localparam int SENS_W   = tcad_pkg::SENS_W;
    localparam int SWEEP_W  = tcad_pkg::SWEEP_W;

    localparam int POS_W    = $clog2(AVG_DEPTH);
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W    = $clog2(NUM_CHANNELS + 1);
    localparam int RAM_AW   = CH_IDX_W + POS_W;
    localparam int RAM_D    = NUM_CHANNELS * (1 << POS_W);
    localparam int SUM_W    = COUNT_W + POS_W;

    // sum / AVG_DEPTH as exact reciprocal multiply: m = ceil(2^(N+l)/d)
    localparam int AVG_SH   = SUM_W + POS_W;
    localparam int AVG_RW   = SUM_W + 2;
    localparam int AVG_PW   = SUM_W + AVG_RW;
    localparam logic [AVG_RW-1:0] AVG_RECIP = AVG_RW'(
        ((64'd1 << AVG_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    // acc / CAL_SWEEPS, same scheme
    localparam int CAL_L    = $clog2(CAL_SWEEPS);
    localparam int CAL_SH   = ACC_W + CAL_L;
    localparam int CAL_RW   = ACC_W + 2;
    localparam int CAL_PW   = ACC_W + CAL_RW;
    localparam logic [CAL_RW-1:0] CAL_RECIP = CAL_RW'(
        ((64'd1 << CAL_SH) + 64'(CAL_SWEEPS) - 64'd1) / 64'(CAL_SWEEPS));

    localparam logic [CH_W-1:0]    LAST_CH   = CH_W'(NUM_CHANNELS - 1);
    localparam logic [CH_W:0]      NUM_CH_X  = (CH_W+1)'(NUM_CHANNELS);
    localparam logic [CNT_W-1:0]   NUM_CH_C  = CNT_W'(NUM_CHANNELS);
    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(AVG_DEPTH - 1);
    localparam logic [SWEEP_W-1:0] SWEEP_END = SWEEP_W'(CAL_SWEEPS);

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    logic [SENS_W-1:0] sens_reg;
    logic              cfg_wr;
    logic              cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr == tcad_pkg::ADDR_SENSITIVITY);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? tcad_pkg::PDATA_W'(sens_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= '0;
        end else if (cfg_wr) begin
            sens_reg <= pwdata[SENS_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------------
    logic busy_reg;
    logic m_tvalid_reg;
    logic adv;
    logic accept;

    // all stages move together; output register frees as it drains
    assign adv      = !busy_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Stage 0: issue ring read, advance ring position
    // ------------------------------------------------------------------------
    tcad_pkg::op_t         in_op;
    logic [CH_W-1:0]       in_ch;
    logic [COUNT_W-1:0]    in_raw;
    logic [CH_IDX_W-1:0]   in_idx;
    logic                  in_range;
    logic                  in_ring;
    logic [POS_W-1:0]      cur_pos;
    logic                  cur_wrap;

    logic [POS_W-1:0]      pos_reg  [NUM_CHANNELS];
    logic                  wrap_reg [NUM_CHANNELS];

    assign in_op    = tcad_pkg::op_t'(s_tuser);
    assign in_ch    = s_tdata[CH_W-1:0];
    assign in_raw   = s_tdata[CH_W +: COUNT_W];
    assign in_idx   = in_ch[CH_IDX_W-1:0];
    assign in_range = ({1'b0, in_ch} < NUM_CH_X);
    assign in_ring  = (in_op == tcad_pkg::OP_SAMPLE) && in_range;
    assign cur_pos  = pos_reg[in_idx];
    assign cur_wrap = wrap_reg[in_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                pos_reg[c]  <= '0;
                wrap_reg[c] <= 1'b0;
            end
        end else if (accept && in_ring) begin
            if (cur_pos == POS_LAST) begin
                pos_reg[in_idx]  <= '0;
                wrap_reg[in_idx] <= 1'b1;   // every entry now written once
            end else begin
                pos_reg[in_idx] <= cur_pos + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: ring RAM data back, running sum update, write new sample
    // ------------------------------------------------------------------------
    logic                  s1_v_reg;
    tcad_pkg::op_t         s1_op_reg;
    logic                  s1_ring_reg;
    logic [CH_W-1:0]       s1_ch_reg;
    logic [COUNT_W-1:0]    s1_raw_reg;
    logic [POS_W-1:0]      s1_pos_reg;
    logic                  s1_old_ok_reg;

    logic [COUNT_W-1:0]    ram_rdata;
    logic [COUNT_W-1:0]    s1_old;
    logic [CH_IDX_W-1:0]   s1_idx;
    logic [SUM_W-1:0]      s1_sum_next;
    logic                  ram_we;
    logic [SUM_W-1:0]      sum_reg [NUM_CHANNELS];

    tcad_ring_mem #(
        .DEPTH  (RAM_D),
        .ADDR_W (RAM_AW),
        .DATA_W (COUNT_W)
    ) u_ring_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr ({s1_idx, s1_pos_reg}),
        .wdata (s1_raw_reg),
        .re    (accept && in_ring),
        .raddr ({in_idx, cur_pos}),
        .rdata (ram_rdata)
    );

    // The next read of a channel is always at a different slot than the
    // write in flight, so the RAM needs no bypass.
    assign s1_idx      = s1_ch_reg[CH_IDX_W-1:0];
    assign s1_old      = s1_old_ok_reg ? ram_rdata : '0;
    assign s1_sum_next = sum_reg[s1_idx] - SUM_W'(s1_old) + SUM_W'(s1_raw_reg);
    assign ram_we      = adv && s1_v_reg && s1_ring_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (ram_we) begin
            sum_reg[s1_idx] <= s1_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg     <= in_op;
            s1_ring_reg   <= in_ring;
            s1_ch_reg     <= in_ch;
            s1_raw_reg    <= in_raw;
            s1_pos_reg    <= cur_pos;
            s1_old_ok_reg <= cur_wrap;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: sum / AVG_DEPTH
    // ------------------------------------------------------------------------
    logic                  s2_v_reg;
    tcad_pkg::op_t         s2_op_reg;
    logic                  s2_ring_reg;
    logic [CH_W-1:0]       s2_ch_reg;
    logic [COUNT_W-1:0]    s2_raw_reg;
    logic [SUM_W-1:0]      s2_sum_reg;
    logic [AVG_PW-1:0]     avg_prod;

    assign avg_prod = {{AVG_RW{1'b0}}, s2_sum_reg} * {{SUM_W{1'b0}}, AVG_RECIP};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_op_reg   <= s1_op_reg;
            s2_ring_reg <= s1_ring_reg;
            s2_ch_reg   <= s1_ch_reg;
            s2_raw_reg  <= s1_raw_reg;
            s2_sum_reg  <= s1_sum_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: accumulate / compare, calibration control, output register
    // ------------------------------------------------------------------------
    logic                  s3_v_reg;
    tcad_pkg::op_t         s3_op_reg;
    logic                  s3_ring_reg;
    logic [CH_W-1:0]       s3_ch_reg;
    logic [COUNT_W-1:0]    s3_raw_reg;
    logic [COUNT_W-1:0]    s3_smooth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_v_reg <= 1'b0;
        end else if (adv) begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_op_reg     <= s2_op_reg;
            s3_ring_reg   <= s2_ring_reg;
            s3_ch_reg     <= s2_ch_reg;
            s3_raw_reg    <= s2_raw_reg;
            s3_smooth_reg <= COUNT_W'(avg_prod >> AVG_SH);
        end
    end

    logic [ACC_W-1:0]      acc_reg [NUM_CHANNELS];
    logic [THR_W-1:0]      thr_reg [NUM_CHANNELS];
    logic [SWEEP_W-1:0]    sweep_reg;
    logic                  in_cal_reg;
    logic [MASK_W-1:0]     mask_reg;

    logic [CNT_W-1:0]      pass_cnt_reg;
    logic                  pass_wr_v_reg;
    logic [CH_IDX_W-1:0]   pass_wr_idx_reg;
    logic [CAL_PW-1:0]     cal_prod_reg;
    logic [SENS_W-1:0]     sens_snap_reg;

    logic                  fire;
    logic                  s3_restart;
    logic                  s3_cal_smp;
    logic                  s3_det_smp;
    logic [CH_IDX_W-1:0]   s3_idx;
    logic [CH_IDX_W-1:0]   acc_idx;
    logic [ACC_W-1:0]      acc_rd;
    logic [ACC_W:0]        acc_sum;
    logic [ACC_W-1:0]      acc_sat;
    logic [SWEEP_W-1:0]    sweep_inc;
    logic                  s3_last;
    logic                  cal_done;
    logic                  touched;
    logic [CH_W-1:0]       mbit;
    logic [MASK_W-1:0]     mask_next;
    logic                  in_cal_next;
    logic [COUNT_W-1:0]    smooth_out;
    logic                  pass_issue;
    logic [ACC_W-1:0]      cal_q;
    logic [THR_W-1:0]      thr_new;

    assign fire       = adv && s3_v_reg;
    assign s3_restart = (s3_op_reg == tcad_pkg::OP_RESTART);
    assign s3_cal_smp = s3_ring_reg && in_cal_reg;
    assign s3_det_smp = s3_ring_reg && !in_cal_reg;
    assign s3_idx     = s3_ch_reg[CH_IDX_W-1:0];

    // one accumulator read port, shared with the threshold load pass
    assign acc_idx   = busy_reg ? pass_cnt_reg[CH_IDX_W-1:0] : s3_idx;
    assign acc_rd    = acc_reg[acc_idx];
    assign acc_sum   = {1'b0, acc_rd} + (ACC_W+1)'(s3_smooth_reg);
    assign acc_sat   = acc_sum[ACC_W] ? tcad_pkg::ACC_MAX : acc_sum[ACC_W-1:0];

    assign sweep_inc = sweep_reg + 1'b1;
    assign s3_last   = (s3_ch_reg == LAST_CH);
    assign cal_done  = s3_cal_smp && s3_last && (sweep_inc >= SWEEP_END);

    assign touched   = s3_det_smp && ((THR_W'(s3_smooth_reg)) > thr_reg[s3_idx]);
    assign mbit      = tcad_pkg::mask_bit_of(s3_ch_reg);

    always_comb begin
        mask_next = mask_reg;
        if (s3_det_smp && ({1'b0, mbit} < (CH_W+1)'(MASK_W))) begin
            mask_next[mbit] = touched;
        end
    end

    always_comb begin
        in_cal_next = in_cal_reg;
        if (s3_restart) begin
            in_cal_next = 1'b1;
        end else if (cal_done) begin
            in_cal_next = 1'b0;
        end
    end

    always_comb begin
        if (s3_restart) begin
            smooth_out = '0;
        end else if (s3_ring_reg) begin
            smooth_out = s3_smooth_reg;
        end else begin
            smooth_out = s3_raw_reg;   // out of range channel echoes the count
        end
    end

    // threshold = acc / CAL_SWEEPS + sensitivity, one channel per cycle
    assign pass_issue = busy_reg && (pass_cnt_reg < NUM_CH_C);
    assign cal_q      = ACC_W'(cal_prod_reg >> CAL_SH);
    assign thr_new    = THR_W'(cal_q + ACC_W'(sens_snap_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                acc_reg[c] <= '0;
                thr_reg[c] <= '0;
            end
            sweep_reg     <= '0;
            in_cal_reg    <= 1'b1;
            mask_reg      <= '0;
            busy_reg      <= 1'b0;
            pass_cnt_reg  <= '0;
            pass_wr_v_reg <= 1'b0;
        end else begin
            if (fire) begin
                in_cal_reg <= in_cal_next;
                mask_reg   <= mask_next;
                if (s3_restart) begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        acc_reg[c] <= '0;
                    end
                    sweep_reg <= '0;
                end else if (s3_cal_smp) begin
                    acc_reg[s3_idx] <= acc_sat;
                    if (s3_last) begin
                        sweep_reg <= sweep_inc;
                    end
                end
                if (cal_done) begin
                    busy_reg     <= 1'b1;
                    pass_cnt_reg <= '0;
                end
            end
            pass_wr_v_reg <= pass_issue;
            if (pass_issue) begin
                pass_cnt_reg <= pass_cnt_reg + 1'b1;
            end
            if (pass_wr_v_reg) begin
                thr_reg[pass_wr_idx_reg] <= thr_new;
                if (pass_wr_idx_reg == LAST_CH[CH_IDX_W-1:0]) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && cal_done) begin
            sens_snap_reg <= sens_reg;
        end
        if (pass_issue) begin
            cal_prod_reg    <= {{CAL_RW{1'b0}}, acc_rd} * {{ACC_W{1'b0}}, CAL_RECIP};
            pass_wr_idx_reg <= pass_cnt_reg[CH_IDX_W-1:0];
        end
    end

    // output register
    logic [COUNT_W-1:0]    out_smooth_reg;
    logic                  out_touched_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic                  out_cal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_smooth_reg  <= smooth_out;
            out_touched_reg <= touched;
            out_mask_reg    <= mask_next;
            out_cal_reg     <= in_cal_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tcad_pkg::M_TDATA_W'({out_mask_reg, out_touched_reg, out_smooth_reg});
    assign m_tuser  = out_cal_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("input accepted during threshold load");

    a_touch_not_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[COUNT_W]) |-> !m_tuser)
        else $error("touch reported while calibrating");

    a_pass_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy_reg) |-> (!in_cal_reg && $past(in_cal_reg)))
        else $error("threshold load started without calibration end");

    a_pass_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pass_cnt_reg <= NUM_CH_C))
        else $error("threshold load counter out of range");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top: regression for touch_channel_averager_detector
// Sends discharge counts and restart commands through the input stream and
// checks every result transaction against an in-bench prediction of the
// channel averages, calibration thresholds and touch mask. The run covers
// several sensitivity settings, full calibrations, random idling on both
// streams and a long receiver hold-off.
// ============================================================================
module tb_top;
    import tcad_pkg::*;

    localparam int NCH           = 5;      // channels in the default build
    localparam int DEPTH         = 8;      // averaging ring depth
    localparam int CAL_SWEEPS    = 1000;   // sweeps per calibration
    localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
    localparam int SETTLE_CYCLES = 16;     // pipeline latency plus threshold load pass
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 10;
    localparam int HOLD_CYCLES   = 120;    // long receiver hold-off
    localparam int DETECT_ITEMS  = 320;    // samples after calibration per phase

    localparam logic [COUNT_W-1:0] FULL_SCALE = '1;

    // One expected result transaction
    typedef struct packed {
        logic [COUNT_W-1:0] smoothed;
        logic               touched;
        logic [MASK_W-1:0]  touch_mask;
        logic               calibrating;
    } reading_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    touch_channel_averager_detector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [2:0] channel, [16:3] raw_count, rest zero
        .s_tuser  (s_tuser),   // [0] op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [13:0] smoothed, [14] touched, [19:15] touch_mask
        .m_tuser  (m_tuser),   // [0] calibrating
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Predicted block state, kept at the block's own widths
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0] ring_q [NCH][DEPTH];
    logic [16:0]        sum_q  [NCH];
    logic [2:0]         slot_q [NCH];
    logic [ACC_W-1:0]   acc_q  [NCH];
    logic [THR_W-1:0]   thr_q  [NCH];
    logic [SWEEP_W-1:0] sweeps_done;
    logic               calibrating_q;
    logic [MASK_W-1:0]  mask_q;
    logic [SENS_W-1:0]  sens_q;

    reading_t expected_readings[$];

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int          send_idle_pct = 0;   // chance the sender skips a cycle
    int          recv_idle_pct = 0;   // chance the receiver drops tready
    int          hold_request  = 0;   // set by the tests, taken by the receiver
    int          hold_left     = 0;

    // Stimulus levels per channel for the current phase
    int          channel_level   [NCH];
    bit          channel_pressed [NCH];

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("touch_channel_averager_detector regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    task automatic reset_prediction();
        for (int c = 0; c < NCH; c++) begin
            for (int k = 0; k < DEPTH; k++)
                ring_q[c][k] = '0;
            sum_q[c]  = '0;
            slot_q[c] = '0;
            acc_q[c]  = '0;
            thr_q[c]  = '0;
        end
        sweeps_done   = '0;
        calibrating_q = 1'b1;
        mask_q        = '0;
        sens_q        = '0;
    endtask

    // Advances the predicted state by one accepted input transaction and
    // queues the result it must produce.
    task automatic predict_touch_reading(input op_t op, input logic [CH_W-1:0] ch,
                                         input logic [COUNT_W-1:0] raw);
        reading_t         r;
        logic [16:0]      avg;
        logic [ACC_W:0]   acc_next;
        int               mask_idx;
        r = '0;
        if (op == OP_RESTART) begin
            // accumulators restart; rings, thresholds and mask are kept
            for (int c = 0; c < NCH; c++)
                acc_q[c] = '0;
            sweeps_done   = '0;
            calibrating_q = 1'b1;
        end else if (ch >= NCH) begin
            // unknown channel: count passes through, nothing changes
            r.smoothed = raw;
        end else begin
            sum_q[ch] = sum_q[ch] - ring_q[ch][slot_q[ch]] + raw;
            ring_q[ch][slot_q[ch]] = raw;
            slot_q[ch] = (slot_q[ch] == DEPTH - 1) ? 3'd0 : slot_q[ch] + 3'd1;
            avg = sum_q[ch] / DEPTH;
            r.smoothed = avg[COUNT_W-1:0];
            if (calibrating_q) begin
                acc_next = {1'b0, acc_q[ch]} + avg;
                acc_q[ch] = (acc_next > ACC_MAX) ? ACC_MAX : acc_next[ACC_W-1:0];
                // a sweep closes on the last channel
                if (ch == NCH - 1) begin
                    sweeps_done = sweeps_done + 1'b1;
                    if (sweeps_done >= CAL_SWEEPS) begin
                        for (int c = 0; c < NCH; c++)
                            thr_q[c] = THR_W'(acc_q[c] / CAL_SWEEPS + sens_q);
                        calibrating_q = 1'b0;
                    end
                end
            end else begin
                r.touched = ({3'b000, r.smoothed} > thr_q[ch]);
                // channels 0 and 1 trade places in the mask
                case (ch)
                    3'd0:    mask_idx = 1;
                    3'd1:    mask_idx = 0;
                    default: mask_idx = ch;
                endcase
                if (mask_idx < MASK_W)
                    mask_q[mask_idx] = r.touched;
            end
        end
        r.touch_mask  = mask_q;
        r.calibrating = calibrating_q;
        expected_readings.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                     what, cycle_count, want, got);
    endtask

    task automatic check_reading();
        reading_t want;
        if (expected_readings.size() == 0) begin
            note_mismatch("result transaction with nothing pending", 0, m_tdata);
        end else begin
            want = expected_readings.pop_front();
            if (m_tdata[COUNT_W-1:0] !== want.smoothed)
                note_mismatch("smoothed", want.smoothed, m_tdata[COUNT_W-1:0]);
            if (m_tdata[COUNT_W] !== want.touched)
                note_mismatch("touched", want.touched, m_tdata[COUNT_W]);
            if (m_tdata[COUNT_W+1 +: MASK_W] !== want.touch_mask)
                note_mismatch("touch_mask", want.touch_mask, m_tdata[COUNT_W+1 +: MASK_W]);
            if (m_tuser !== want.calibrating)
                note_mismatch("calibrating", want.calibrating, m_tuser);
        end
    endtask

    // Receiver: checks each accepted result, then picks tready for the next
    // edge. A hold-off request overrides the random stalls for its length.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_reading();
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Offers one item and returns at the edge where it was taken. tvalid
    // stays high so a following call keeps the stream busy without a gap.
    task automatic send_item(input op_t op, input logic [CH_W-1:0] ch,
                             input logic [COUNT_W-1:0] raw);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[CH_W-1:0]       = ch;
        word[CH_W +: COUNT_W] = raw;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        predict_touch_reading(op, ch, raw);
    endtask

    // Stops the input and waits for every pending result plus the tail of
    // the pipeline (threshold load pass included).
    task automatic drain_readings();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write_sensitivity(input logic [SENS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SENSITIVITY;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sens_q = value;
        @(posedge aclk);
    endtask

    task automatic apb_check_sensitivity();
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SENSITIVITY;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PDATA_W'(sens_q))
            note_mismatch("sensitivity readback", sens_q, got);
        @(posedge aclk);
    endtask

    // Count around a center, clipped to the count range
    function automatic logic [COUNT_W-1:0] near_level(input int center, input int span);
        int v;
        v = center + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COUNT_MAX)
            v = COUNT_MAX;
        return v[COUNT_W-1:0];
    endfunction

    // Well-formed calibration sweeps: the last channel always closes a sweep,
    // the others show up now and then, with rare unknown-channel noise.
    task automatic run_calibration_sweeps(input int count);
        for (int s = 0; s < count; s++) begin
            for (int c = 0; c < NCH - 1; c++)
                if ($urandom_range(7) == 0)
                    send_item(OP_SAMPLE, CH_W'(c), near_level(channel_level[c], 40));
            if ($urandom_range(49) == 0)
                send_item(OP_SAMPLE, CH_W'($urandom_range(7, NCH)), COUNT_W'($urandom));
            send_item(OP_SAMPLE, CH_W'(NCH - 1), near_level(channel_level[NCH-1], 40));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Field extremes, every op, unknown channels, restarts with junk fields
    // and a full ring of full-scale counts.
    task automatic test_directed_extremes();
        send_idle_pct = 21;
        recv_idle_pct = 49;
        apb_check_sensitivity();            // reset value
        apb_write_sensitivity(16'h0000);
        apb_check_sensitivity();
        send_item(OP_SAMPLE, 3'd0, FULL_SCALE);
        send_item(OP_SAMPLE, 3'd1, '0);
        send_item(OP_SAMPLE, 3'd2, FULL_SCALE);
        send_item(OP_SAMPLE, 3'd3, 14'd1);
        send_item(OP_SAMPLE, 3'd4, FULL_SCALE);   // closes the first sweep
        send_item(OP_SAMPLE, 3'd5, FULL_SCALE);   // unknown channels pass through
        send_item(OP_SAMPLE, 3'd6, 14'h2AAA);
        send_item(OP_SAMPLE, 3'd7, 14'h1555);
        send_item(OP_RESTART, 3'd7, FULL_SCALE);  // channel and count ignored
        send_item(OP_RESTART, 3'd0, '0);
        send_item(OP_SAMPLE, 3'd4, '0);
        repeat (DEPTH) send_item(OP_SAMPLE, 3'd0, FULL_SCALE);   // ring wraps
        send_item(OP_SAMPLE, 3'd1, FULL_SCALE);
        send_item(OP_SAMPLE, 3'd3, FULL_SCALE);
        drain_readings();
    endtask

    // One full calibration at the given sensitivity, then touch detection
    // with channels being pressed and released. Midway the receiver holds
    // off for a long stretch while items keep coming, and later the sender
    // waits for the block to empty.
    task automatic test_calibrate_and_detect(input logic [SENS_W-1:0] sens,
                                             input int send_pct, input int recv_pct);
        int                 c;
        logic [COUNT_W-1:0] raw;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        apb_write_sensitivity(sens);
        apb_check_sensitivity();
        for (int k = 0; k < NCH; k++) begin
            channel_level[k]   = $urandom_range(12000, 200);
            channel_pressed[k] = 1'b0;
        end
        send_item(OP_RESTART, CH_W'($urandom), COUNT_W'($urandom));
        // broken sequence: a restart a few sweeps into calibration
        run_calibration_sweeps($urandom_range(12, 2));
        send_item(OP_RESTART, CH_W'($urandom), COUNT_W'($urandom));
        run_calibration_sweeps(CAL_SWEEPS);

        for (int n = 0; n < DETECT_ITEMS; n++) begin
            if (n == 100)
                hold_request = HOLD_CYCLES;
            if (n == 200)
                drain_readings();
            if ($urandom_range(15) == 0) begin
                send_item(OP_SAMPLE, CH_W'($urandom_range(7, NCH)), COUNT_W'($urandom));
            end else begin
                c = $urandom_range(NCH - 1);
                if ($urandom_range(11) == 0)
                    channel_pressed[c] = !channel_pressed[c];
                if ($urandom_range(9) == 0)
                    raw = COUNT_W'($urandom);
                else if (channel_pressed[c])
                    raw = near_level(channel_level[c] + 1500, 200);
                else
                    raw = near_level(channel_level[c], 40);
                send_item(OP_SAMPLE, CH_W'(c), raw);
            end
        end
        drain_readings();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_prediction();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_calibrate_and_detect(16'h0000, 21, 49);   // lowest threshold
        test_calibrate_and_detect(16'hFFFF, 49, 21);   // threshold out of reach
        test_calibrate_and_detect(SENS_W'($urandom_range(3000, 1)), 0, 0);

        if (mismatches == 0)
            $display("touch_channel_averager_detector regression: pass");
        else
            $display("touch_channel_averager_detector regression: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/tcad_pkg.sv
sv/tcad_ring_mem.sv
sv/touch_channel_averager_detector.sv
sim/tb_top.sv
